/* hw/rtl/png_s2r_pkg.sv */
package png_s2r_pkg;

   // Input word: scanline byte or palette entry write
   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
      logic [7:0] palette_index;
      logic [7:0] palette_red;
      logic [7:0] palette_green;
      logic [7:0] palette_blue;
   } req_word_type;

   // Result word: one RGBA8 pixel or a filter flag
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       pixel_last;
      logic       status;
   } rsp_word_type;

   localparam logic REQ_SCANLINE = 1'b0;
   localparam logic REQ_PALETTE  = 1'b1;

   localparam int CSR_DATA_W = 13;
   localparam logic [1:0] CSR_COLOR_TYPE  = 2'd0;
   localparam logic [1:0] CSR_BIT_DEPTH   = 2'd1;
   localparam logic [1:0] CSR_IMAGE_WIDTH = 2'd2;

   localparam logic [4:0] DEPTH_1  = 5'd1;
   localparam logic [4:0] DEPTH_2  = 5'd2;
   localparam logic [4:0] DEPTH_4  = 5'd4;
   localparam logic [4:0] DEPTH_8  = 5'd8;
   localparam logic [4:0] DEPTH_16 = 5'd16;

   localparam logic [7:0] FULL_ALPHA = 8'd255;

   typedef enum logic [2:0] {
      COLOR_GRAY       = 3'd0,
      COLOR_RGB        = 3'd2,
      COLOR_PALETTE    = 3'd3,
      COLOR_GRAY_ALPHA = 3'd4,
      COLOR_RGBA       = 3'd6
   } color_type_type;

   // Decoded format as the unpacker sees it
   typedef struct packed {
      color_type_type color;
      logic [4:0]     depth;
      logic [12:0]    width;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_DIRECT,
      OP_PALETTE,
      OP_FLAG,
      OP_PAL_WRITE
   } smp_op_type;

   // Word from the unpacker to the color stage
   typedef struct packed {
      smp_op_type op;
      logic [7:0] index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } smp_type;

   // Map unknown color types to gray
   function automatic color_type_type decode_color(input logic [2:0] raw);
      color_type_type c;
      unique case (raw)
         COLOR_RGB:        c = COLOR_RGB;
         COLOR_PALETTE:    c = COLOR_PALETTE;
         COLOR_GRAY_ALPHA: c = COLOR_GRAY_ALPHA;
         COLOR_RGBA:       c = COLOR_RGBA;
         default:          c = COLOR_GRAY;
      endcase
      return c;
   endfunction

   // Map depths the color type does not allow to 8
   function automatic logic [4:0] decode_depth(input color_type_type c, input logic [4:0] raw);
      logic ok;
      unique case (c)
         COLOR_GRAY:    ok = (raw == DEPTH_1) || (raw == DEPTH_2) || (raw == DEPTH_4) ||
                             (raw == DEPTH_8) || (raw == DEPTH_16);
         COLOR_PALETTE: ok = (raw == DEPTH_1) || (raw == DEPTH_2) || (raw == DEPTH_4) ||
                             (raw == DEPTH_8);
         default:       ok = (raw == DEPTH_8) || (raw == DEPTH_16);
      endcase
      return ok ? raw : DEPTH_8;
   endfunction

endpackage

/* hw/rtl/png_s2r_unpack.sv */
module png_s2r_unpack #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  png_s2r_pkg::cfg_type       cfg,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  png_s2r_pkg::req_word_type  req_data,
   output logic                       smp_valid,
   input  logic                       smp_ready,
   output png_s2r_pkg::smp_type       smp_data
);
   import png_s2r_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int SW = CW + 4;

   logic              expect_filter_ff, expect_filter_in;
   logic [CW-1:0]     pixel_count_ff, pixel_count_in;
   logic [6:0][7:0]   sample_buffer_ff, sample_buffer_in;
   logic [2:0]        sample_fill_ff, sample_fill_in;
   logic [2:0]        remain_ff, remain_in;
   logic [7:0]        shift_ff, shift_in;
   logic              smp_valid_ff, smp_valid_in;
   smp_type           smp_ff, smp_in;

   logic              can_load, accept, step, load;
   logic              sub, is_pal, d16, complete, row_done;
   logic [CW-1:0]     width_eff;
   logic [3:0]        per, n, n_pix;
   logic [SW-1:0]     left_in_row, count_sum;
   logic [2:0]        chans;
   logic [3:0]        bpp;
   logic [7:0]        b [8];
   logic [7:0]        s [4];
   logic [7:0]        byte_in;

   // Take the top sample of a left-aligned byte
   function automatic smp_type sub_sample(input logic [7:0] sh, input logic [4:0] depth,
                                          input logic pal, input logic last);
      smp_type    w;
      logic [7:0] v;
      logic [7:0] g;
      unique case (depth)
         DEPTH_1: begin
            v = {7'd0, sh[7]};
            g = {8{sh[7]}};
         end
         DEPTH_2: begin
            v = {6'd0, sh[7:6]};
            g = {4{sh[7:6]}};
         end
         default: begin
            v = {4'd0, sh[7:4]};
            g = {2{sh[7:4]}};
         end
      endcase
      w.op    = pal ? OP_PALETTE : OP_DIRECT;
      w.index = v;
      w.red   = g;
      w.green = g;
      w.blue  = g;
      w.alpha = FULL_ALPHA;
      w.last  = last;
      return w;
   endfunction

   // Clamp width into 1..MAX_WIDTH
   always_comb begin
      if (cfg.width == '0) begin
         width_eff = CW'(1);
      end else if (32'(cfg.width) > 32'(MAX_WIDTH)) begin
         width_eff = CW'(MAX_WIDTH);
      end else begin
         width_eff = CW'(cfg.width);
      end
   end

   // Pixels per byte and pixels left in the row
   always_comb begin
      byte_in = req_data.data_byte;
      sub     = cfg.depth < DEPTH_8;
      is_pal  = cfg.color == COLOR_PALETTE;
      d16     = cfg.depth == DEPTH_16;
      unique case (cfg.depth)
         DEPTH_1: per = 4'd8;
         DEPTH_2: per = 4'd4;
         default: per = 4'd2;
      endcase
      if (SW'(pixel_count_ff) < SW'(width_eff)) begin
         left_in_row = SW'(width_eff) - SW'(pixel_count_ff);
      end else begin
         left_in_row = SW'(1);
      end
      n         = (SW'(per) < left_in_row) ? per : left_in_row[3:0];
      n_pix     = sub ? n : 4'd1;
      count_sum = SW'(pixel_count_ff) + SW'(n_pix);
      row_done  = count_sum >= SW'(width_eff);
   end

   // Assemble a whole pixel from buffered bytes and this byte
   always_comb begin
      unique case (cfg.color)
         COLOR_RGB:        chans = 3'd3;
         COLOR_GRAY_ALPHA: chans = 3'd2;
         COLOR_RGBA:       chans = 3'd4;
         default:          chans = 3'd1;
      endcase
      bpp      = d16 ? {chans, 1'b0} : {1'b0, chans};
      complete = (4'(sample_fill_ff) + 4'd1) >= bpp;
      for (int k = 0; k < 7; k++) begin
         b[k] = (4'(k) == bpp - 4'd1) ? byte_in : sample_buffer_ff[k];
      end
      b[7] = (bpp == 4'd8) ? byte_in : 8'd0;
      for (int k = 0; k < 4; k++) begin
         s[k] = d16 ? 8'((9'(b[2*k]) + 9'(b[2*k+1])) >> 1) : b[k];
      end
   end

   // Handshake: one word in per free output slot, none while unpacking
   assign can_load  = !smp_valid_ff || smp_ready;
   assign req_stall = (remain_ff != 3'd0) || !can_load;
   assign accept    = req_valid && !req_stall;
   assign step      = (remain_ff != 3'd0) && can_load;

   // Row state, unpacker and output word
   always_comb begin
      expect_filter_in = expect_filter_ff;
      pixel_count_in   = pixel_count_ff;
      sample_buffer_in = sample_buffer_ff;
      sample_fill_in   = sample_fill_ff;
      remain_in        = remain_ff;
      shift_in         = shift_ff;
      smp_in           = smp_ff;
      load             = 1'b0;

      if (step) begin
         // emit the next sample of a packed byte
         smp_in    = sub_sample(shift_ff, cfg.depth, is_pal, remain_ff == 3'd1);
         shift_in  = 8'(shift_ff << cfg.depth);
         remain_in = remain_ff - 3'd1;
         load      = 1'b1;
      end else if (accept) begin
         if (req_data.req_type == REQ_PALETTE) begin
            smp_in.op    = OP_PAL_WRITE;
            smp_in.index = req_data.palette_index;
            smp_in.red   = req_data.palette_red;
            smp_in.green = req_data.palette_green;
            smp_in.blue  = req_data.palette_blue;
            smp_in.alpha = FULL_ALPHA;
            smp_in.last  = 1'b0;
            load         = 1'b1;
         end else if (expect_filter_ff) begin
            // filter byte opens the row
            expect_filter_in = 1'b0;
            pixel_count_in   = '0;
            sample_fill_in   = '0;
            sample_buffer_in = '0;
            if (byte_in != 8'd0) begin
               smp_in.op    = OP_FLAG;
               smp_in.index = 8'd0;
               smp_in.red   = 8'd0;
               smp_in.green = 8'd0;
               smp_in.blue  = 8'd0;
               smp_in.alpha = 8'd0;
               smp_in.last  = 1'b0;
               load         = 1'b1;
            end
         end else if (sub || complete) begin
            if (sub) begin
               smp_in    = sub_sample(byte_in, cfg.depth, is_pal, n == 4'd1);
               shift_in  = 8'(byte_in << cfg.depth);
               remain_in = 3'(n - 4'd1);
            end else begin
               smp_in.op    = is_pal ? OP_PALETTE : OP_DIRECT;
               smp_in.index = s[0];
               smp_in.last  = 1'b1;
               unique case (cfg.color)
                  COLOR_RGB: begin
                     smp_in.red   = s[0];
                     smp_in.green = s[1];
                     smp_in.blue  = s[2];
                     smp_in.alpha = FULL_ALPHA;
                  end
                  COLOR_GRAY_ALPHA: begin
                     smp_in.red   = s[0];
                     smp_in.green = s[0];
                     smp_in.blue  = s[0];
                     smp_in.alpha = s[1];
                  end
                  COLOR_RGBA: begin
                     smp_in.red   = s[0];
                     smp_in.green = s[1];
                     smp_in.blue  = s[2];
                     smp_in.alpha = s[3];
                  end
                  default: begin
                     smp_in.red   = s[0];
                     smp_in.green = s[0];
                     smp_in.blue  = s[0];
                     smp_in.alpha = FULL_ALPHA;
                  end
               endcase
            end
            load             = 1'b1;
            sample_fill_in   = '0;
            sample_buffer_in = '0;
            // advance the pixel count, close the row at the width
            if (row_done) begin
               expect_filter_in = 1'b1;
               pixel_count_in   = '0;
            end else begin
               pixel_count_in = CW'(count_sum);
            end
         end else begin
            // hold a partial pixel
            for (int k = 0; k < 7; k++) begin
               if (3'(k) == sample_fill_ff) begin
                  sample_buffer_in[k] = byte_in;
               end
            end
            sample_fill_in = sample_fill_ff + 3'd1;
         end
      end

      if (load) begin
         smp_valid_in = 1'b1;
      end else if (smp_ready) begin
         smp_valid_in = 1'b0;
      end else begin
         smp_valid_in = smp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_filter_ff <= 1'b1;
         pixel_count_ff   <= '0;
         sample_buffer_ff <= '0;
         sample_fill_ff   <= '0;
         remain_ff        <= '0;
         smp_valid_ff     <= 1'b0;
      end else begin
         expect_filter_ff <= expect_filter_in;
         pixel_count_ff   <= pixel_count_in;
         sample_buffer_ff <= sample_buffer_in;
         sample_fill_ff   <= sample_fill_in;
         remain_ff        <= remain_in;
         smp_valid_ff     <= smp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      smp_ff   <= smp_in;
   end

   assign smp_valid = smp_valid_ff;
   assign smp_data  = smp_ff;

endmodule

/* hw/rtl/png_s2r_color.sv */
module png_s2r_color #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       smp_valid,
   output logic                       smp_ready,
   input  png_s2r_pkg::smp_type       smp_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output png_s2r_pkg::rsp_word_type  rsp_data
);
   import png_s2r_pkg::*;

   localparam int AW = $clog2(PALETTE_ENTRIES);

   logic [23:0]   palette_mem [PALETTE_ENTRIES];

   logic          s2_valid_ff, s2_valid_in;
   smp_type       s2_ff;
   logic          s2_hit_ff;
   logic [23:0]   rd_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_ff, rsp_in;

   logic          out_load, s2_move, take, take_pix, take_wr, in_range;
   logic [AW-1:0] addr;

   // Pipeline flow: read stage moves when the output register frees
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign s2_move   = s2_valid_ff && out_load;
   assign smp_ready = !s2_valid_ff || out_load;
   assign take      = smp_valid && smp_ready;
   assign take_wr   = take && (smp_data.op == OP_PAL_WRITE);
   assign take_pix  = take && (smp_data.op != OP_PAL_WRITE);
   assign in_range  = 9'(smp_data.index) < 9'(PALETTE_ENTRIES);
   assign addr      = smp_data.index[AW-1:0];

   // Palette: writes and reads in stream order at one point
   always_ff @(posedge clock) begin
      if (take_wr && in_range) begin
         palette_mem[addr] <= {smp_data.red, smp_data.green, smp_data.blue};
      end
      if (take_pix && in_range) begin
         rd_data_ff <= palette_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (take_pix) begin
         s2_ff     <= smp_data;
         s2_hit_ff <= in_range;
      end
   end

   // Final pixel from direct channels or palette data
   always_comb begin
      rsp_in.pixel_last = s2_ff.last;
      rsp_in.status     = 1'b0;
      unique case (s2_ff.op)
         OP_PALETTE: begin
            rsp_in.red   = s2_hit_ff ? rd_data_ff[23:16] : 8'd0;
            rsp_in.green = s2_hit_ff ? rd_data_ff[15:8]  : 8'd0;
            rsp_in.blue  = s2_hit_ff ? rd_data_ff[7:0]   : 8'd0;
            rsp_in.alpha = FULL_ALPHA;
         end
         OP_FLAG: begin
            rsp_in.red        = 8'd0;
            rsp_in.green      = 8'd0;
            rsp_in.blue       = 8'd0;
            rsp_in.alpha      = 8'd0;
            rsp_in.pixel_last = 1'b0;
            rsp_in.status     = 1'b1;
         end
         default: begin
            rsp_in.red   = s2_ff.red;
            rsp_in.green = s2_ff.green;
            rsp_in.blue  = s2_ff.blue;
            rsp_in.alpha = s2_ff.alpha;
         end
      endcase
   end

   always_comb begin
      if (take_pix) begin
         s2_valid_in = 1'b1;
      end else if (s2_move) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
      if (s2_move) begin
         rsp_valid_in = 1'b1;
      end else if (out_load) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/png_scanline_to_rgba_core.sv */
// PNG scanline unpacker: inflated scanline bytes in, RGBA8 pixels out.
// Input channel (req_*): one word per accepted cycle, either a scanline byte
// (filter byte first in each row) or a palette entry write. Result channel
// (rsp_*): one pixel per word; a nonzero filter byte gives one flag word.
// Configuration (csr_*): color type, bit depth and row width, written while
// the block is idle; index 0, 1, 2 in that order.
// A result word passes the unpack, palette read and output registers in
// that order before it shows on rsp_*.
// Throughput: one input word per cycle at depths 8 and 16 while the pipe moves.
// A packed byte at depth 1, 2 or 4 holds the input until every pixel it yields
// (up to 8) is issued, one pixel per cycle into the palette read when unstalled.
// Palette writes travel down the same pipe, so reads always see every
// earlier write.
// Reset clears row state and loads the default format (RGBA, depth 8,
// width 1); palette contents are undefined until written.
// When the receiver stalls, the output word holds; req_stall rises once the
// three pipeline stages are full.
module png_scanline_to_rgba_core #(
   parameter int MAX_WIDTH       = 4096,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  png_s2r_pkg::req_word_type              req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output png_s2r_pkg::rsp_word_type              rsp_data,
   input  logic                                   csr_we,
   input  logic [1:0]                             csr_index,
   input  logic [png_s2r_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import png_s2r_pkg::*;

   logic [2:0]  color_type_ff;
   logic [4:0]  bit_depth_ff;
   logic [12:0] image_width_ff;
   cfg_type     cfg;

   logic        smp_valid, smp_ready;
   smp_type     smp_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         color_type_ff  <= COLOR_RGBA;
         bit_depth_ff   <= DEPTH_8;
         image_width_ff <= 13'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COLOR_TYPE:  color_type_ff  <= csr_wdata[2:0];
            CSR_BIT_DEPTH:   bit_depth_ff   <= csr_wdata[4:0];
            CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // Decode the format
   always_comb begin
      cfg.color = decode_color(color_type_ff);
      cfg.depth = decode_depth(cfg.color, bit_depth_ff);
      cfg.width = image_width_ff;
   end

   png_s2r_unpack #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_unpack (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .smp_valid (smp_valid),
      .smp_ready (smp_ready),
      .smp_data  (smp_data)
   );

   png_s2r_color #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_color (
      .clock     (clock),
      .reset     (reset),
      .smp_valid (smp_valid),
      .smp_ready (smp_ready),
      .smp_data  (smp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/png_s2r_checker.sv */
module png_s2r_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input png_s2r_pkg::rsp_word_type  rsp_data
);
   import png_s2r_pkg::*;

   // Reset empties the pipe and opens the input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipe not empty after reset");

   // Stalled result word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Filter flag carries no pixel
   a_flag_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0 &&
         rsp_data.alpha == 8'd0 && !rsp_data.pixel_last)
      else $error("filter flag with pixel data");

endmodule

bind png_scanline_to_rgba_core png_s2r_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import png_s2r_pkg::*;

   localparam int unsigned MAX_W         = 4096;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          LONG_HOLD     = 150;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_word_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_word_type          rsp_data;
   logic                  csr_we;
   logic [1:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow of the unpacker: palette, row position and buffered bytes
   logic [23:0]  pal_rgb [256];
   bit           pal_written [256];
   bit           at_filter;
   int unsigned  px_count;
   int unsigned  held_fill;
   logic [7:0]   held_bytes [8];
   logic [2:0]   cfg_color;
   logic [4:0]   cfg_depth;
   logic [12:0]  cfg_width;
   rsp_word_type pending_pixels [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   bit tx_quiet       = 1'b0;
   bit rx_quiet       = 1'b0;
   int long_hold_ask  = 0;
   int long_hold_seen = 0;
   int rx_left        = 0;

   png_scanline_to_rgba_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Map unsupported color types to gray
   function automatic color_type_type eff_color();
      case (cfg_color)
         COLOR_RGB, COLOR_PALETTE, COLOR_GRAY_ALPHA, COLOR_RGBA: return color_type_type'(cfg_color);
         default: return COLOR_GRAY;
      endcase
   endfunction

   // Fall back to depth 8 when the type does not allow the written depth
   function automatic int unsigned eff_depth(input color_type_type c);
      bit ok;
      case (cfg_depth)
         DEPTH_1, DEPTH_2, DEPTH_4: ok = (c == COLOR_GRAY) || (c == COLOR_PALETTE);
         DEPTH_8:                   ok = 1'b1;
         DEPTH_16:                  ok = (c != COLOR_PALETTE);
         default:                   ok = 1'b0;
      endcase
      return ok ? int'(cfg_depth) : 8;
   endfunction

   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_W) return MAX_W;
      return cfg_width;
   endfunction

   function automatic int unsigned channel_count(input color_type_type c);
      case (c)
         COLOR_RGB:        return 3;
         COLOR_GRAY_ALPHA: return 2;
         COLOR_RGBA:       return 4;
         default:          return 1;
      endcase
   endfunction

   // Bytes after the filter byte that make up one full row
   function automatic int unsigned row_bytes();
      color_type_type c = eff_color();
      int unsigned    d = eff_depth(c);
      if (d < 8) return (eff_width() * d + 7) / 8;
      return eff_width() * channel_count(c) * (d / 8);
   endfunction

   // Pick a scanline byte; a palette index at depth 8 only hits written entries
   function automatic logic [7:0] next_scan_byte();
      int unsigned idx;
      if (at_filter) return ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      if (eff_color() == COLOR_PALETTE && eff_depth(COLOR_PALETTE) == 8) begin
         do idx = $urandom_range(0, 255); while (!pal_written[idx]);
         return 8'(idx);
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic reset_shadow();
      for (int i = 0; i < 256; i++) begin
         pal_rgb[i]     = '0;
         pal_written[i] = 1'b0;
      end
      at_filter = 1'b1;
      px_count  = 0;
      held_fill = 0;
      cfg_color = COLOR_RGBA;
      cfg_depth = DEPTH_8;
      cfg_width = 13'd1;
   endtask

   // Count one pixel; at row end clear the row and wait for a filter byte
   task automatic advance_pixel(input int unsigned wd);
      px_count++;
      if (px_count >= wd) begin
         at_filter = 1'b1;
         px_count  = 0;
         held_fill = 0;
      end
   endtask

   // Work out the pixels one accepted word yields and queue them
   task automatic predict_pixels(input req_word_type w);
      color_type_type c;
      int unsigned    d, wd, per, n, remain, v, mask, chans, bpp, g;
      logic [7:0]     b [8];
      logic [7:0]     s [4];
      logic [23:0]    rgb;
      rsp_word_type   px;
      if (w.req_type == REQ_PALETTE) begin
         pal_rgb[w.palette_index]     = {w.palette_red, w.palette_green, w.palette_blue};
         pal_written[w.palette_index] = 1'b1;
         return;
      end
      if (at_filter) begin
         at_filter = 1'b0;
         px_count  = 0;
         held_fill = 0;
         if (w.data_byte != 8'h00) begin
            px        = '0;
            px.status = 1'b1;
            pending_pixels.push_back(px);
         end
         return;
      end
      c  = eff_color();
      d  = eff_depth(c);
      wd = eff_width();
      if (d < 8) begin
         // Packed samples, most significant first; padding past row end dropped
         per       = 8 / d;
         mask      = (1 << d) - 1;
         remain    = (px_count < wd) ? wd - px_count : 1;
         n         = (per < remain) ? per : remain;
         held_fill = 0;
         for (int i = 0; i < n; i++) begin
            v             = (w.data_byte >> (8 - d * (i + 1))) & mask;
            px            = '0;
            px.alpha      = FULL_ALPHA;
            px.pixel_last = (i + 1 == n);
            if (c == COLOR_PALETTE) begin
               rgb      = pal_rgb[v];
               px.red   = rgb[23:16];
               px.green = rgb[15:8];
               px.blue  = rgb[7:0];
            end else begin
               g        = v * (255 / mask);
               px.red   = 8'(g);
               px.green = 8'(g);
               px.blue  = 8'(g);
            end
            pending_pixels.push_back(px);
         end
         repeat (n) advance_pixel(wd);
      end else begin
         // Whole-byte samples: buffer until the pixel is complete
         chans = channel_count(c);
         bpp   = chans * (d / 8);
         if (held_fill + 1 < bpp) begin
            held_bytes[held_fill] = w.data_byte;
            held_fill++;
            return;
         end
         for (int k = 0; k + 1 < bpp; k++) b[k] = held_bytes[k];
         b[bpp - 1] = w.data_byte;
         held_fill  = 0;
         for (int k = 0; k < chans; k++)
            s[k] = (d == 16) ? 8'(({1'b0, b[2 * k]} + b[2 * k + 1]) >> 1) : b[k];
         px            = '0;
         px.alpha      = FULL_ALPHA;
         px.pixel_last = 1'b1;
         case (c)
            COLOR_RGB: begin
               px.red   = s[0];
               px.green = s[1];
               px.blue  = s[2];
            end
            COLOR_PALETTE: begin
               rgb      = pal_rgb[s[0]];
               px.red   = rgb[23:16];
               px.green = rgb[15:8];
               px.blue  = rgb[7:0];
            end
            COLOR_GRAY_ALPHA: begin
               px.red   = s[0];
               px.green = s[0];
               px.blue  = s[0];
               px.alpha = s[1];
            end
            COLOR_RGBA: begin
               px.red   = s[0];
               px.green = s[1];
               px.blue  = s[2];
               px.alpha = s[3];
            end
            default: begin
               px.red   = s[0];
               px.green = s[0];
               px.blue  = s[0];
            end
         endcase
         pending_pixels.push_back(px);
         advance_pixel(wd);
      end
   endtask

   // Offer one word after a random gap and hold it until accepted
   task automatic send_word(input req_word_type w);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      predict_pixels(w);
   endtask

   task automatic send_scan(input logic [7:0] v);
      req_word_type w;
      w               = '0;
      w.req_type      = REQ_SCANLINE;
      w.data_byte     = v;
      w.palette_index = 8'($urandom);
      {w.palette_red, w.palette_green, w.palette_blue} = 24'($urandom);
      send_word(w);
   endtask

   task automatic send_palette(input logic [7:0] idx, input logic [23:0] rgb);
      req_word_type w;
      w               = '0;
      w.req_type      = REQ_PALETTE;
      w.data_byte     = 8'($urandom);
      w.palette_index = idx;
      {w.palette_red, w.palette_green, w.palette_blue} = rgb;
      send_word(w);
   endtask

   // Drop valid and hold until every pending pixel has arrived
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; the caller lowers the write enable
   task automatic write_reg(input logic [1:0] idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      case (idx)
         CSR_COLOR_TYPE:  cfg_color = value[2:0];
         CSR_BIT_DEPTH:   cfg_depth = value[4:0];
         CSR_IMAGE_WIDTH: cfg_width = value[12:0];
         default: ;
      endcase
   endtask

   task automatic set_format(input logic [2:0] color, input int unsigned depth,
                             input int unsigned width);
      wait_for_results();
      write_reg(CSR_COLOR_TYPE, color);
      write_reg(CSR_BIT_DEPTH, depth);
      write_reg(CSR_IMAGE_WIDTH, width);
      csr_we <= 1'b0;
   endtask

   task automatic change_reg(input logic [1:0] idx, input int unsigned value);
      wait_for_results();
      write_reg(idx, value);
      csr_we <= 1'b0;
   endtask

   // Default format after reset, plus an unsupported filter byte
   task automatic test_reset_format();
      send_scan(8'h00);
      send_scan(8'h00);
      send_scan(8'hFF);
      send_scan(8'h00);
      send_scan(8'hFF);
      send_scan(8'hFF);
      send_scan(8'hFF);
      send_scan(8'h00);
      send_scan(8'h80);
      send_scan(8'h7F);
   endtask

   // Gray at every depth: bit replication, padding, 16-bit averaging
   task automatic test_gray_depths();
      set_format(COLOR_GRAY, DEPTH_1, 8);
      send_scan(8'h00);
      send_scan(8'hA5);
      set_format(COLOR_GRAY, DEPTH_2, 3);
      send_scan(8'h00);
      send_scan(8'hE4);
      set_format(COLOR_GRAY, DEPTH_4, 2);
      send_scan(8'h00);
      send_scan(8'h0F);
      set_format(COLOR_GRAY, DEPTH_16, 1);
      send_scan(8'h00);
      send_scan(8'hFF);
      send_scan(8'hFE);
      set_format(COLOR_GRAY, DEPTH_8, 2);
      send_scan(8'h01);
      send_scan(8'h00);
      send_scan(8'hFF);
   endtask

   task automatic test_color_formats();
      set_format(COLOR_RGB, DEPTH_8, 1);
      send_scan(8'h00);
      send_scan(8'h01);
      send_scan(8'h80);
      send_scan(8'hFF);
      set_format(COLOR_GRAY_ALPHA, DEPTH_16, 1);
      send_scan(8'h00);
      for (int i = 0; i < 4; i++) send_scan(8'($urandom));
      set_format(COLOR_RGBA, DEPTH_16, 1);
      send_scan(8'h00);
      for (int i = 0; i < 8; i++) send_scan(8'($urandom));
   endtask

   // Load six palette entries, then read them back at palette depths 2, 8 and 1
   task automatic test_palette();
      send_palette(8'd0, 24'h000000);
      send_palette(8'd1, 24'hFFFFFF);
      send_palette(8'd2, 24'($urandom));
      send_palette(8'd3, 24'($urandom));
      send_palette(8'd170, 24'($urandom));
      send_palette(8'd255, 24'($urandom));
      set_format(COLOR_PALETTE, DEPTH_2, 4);
      send_scan(8'h00);
      send_scan(8'h1B);
      set_format(COLOR_PALETTE, DEPTH_8, 2);
      send_scan(8'h00);
      send_scan(8'd255);
      send_scan(8'd170);
      set_format(COLOR_PALETTE, DEPTH_1, 3);
      send_scan(8'h00);
      send_scan(8'hA0);
   endtask

   // Unknown color types, disallowed depths and width 0
   task automatic test_bad_config();
      set_format(3'd7, 3, 0);
      send_scan(8'h00);
      send_scan(8'h5A);
      set_format(3'd5, DEPTH_16, 1);
      send_scan(8'h00);
      send_scan(8'h10);
      send_scan(8'h21);
      set_format(COLOR_PALETTE, DEPTH_16, 1);
      send_scan(8'h00);
      send_scan(8'd2);
      set_format(COLOR_RGBA, 0, 1);
      send_scan(8'h00);
      for (int i = 0; i < 4; i++) send_scan(8'($urandom));
      set_format(3'd1, 31, 1);
      send_scan(8'h00);
      send_scan(8'h33);
   endtask

   // Registers rewritten in the middle of a row
   task automatic test_mid_row_change();
      // count already past the new width: next byte ends the row
      set_format(COLOR_GRAY, DEPTH_8, 5);
      send_scan(8'h00);
      send_scan(8'h10);
      send_scan(8'h20);
      send_scan(8'h30);
      change_reg(CSR_IMAGE_WIDTH, 2);
      send_scan(8'h40);
      // same at a packed depth
      set_format(COLOR_GRAY, DEPTH_1, 16);
      send_scan(8'h00);
      send_scan(8'hF0);
      change_reg(CSR_IMAGE_WIDTH, 4);
      send_scan(8'h80);
      // more bytes buffered than the new pixel size needs
      set_format(COLOR_RGBA, DEPTH_8, 2);
      send_scan(8'h00);
      send_scan(8'h11);
      send_scan(8'h22);
      send_scan(8'h33);
      change_reg(CSR_COLOR_TYPE, COLOR_RGB);
      send_scan(8'h44);
   endtask

   // Widest register value keeps the row open; a narrow width then closes it
   task automatic test_widest_row();
      set_format(COLOR_GRAY, DEPTH_1, (1 << CSR_DATA_W) - 1);
      send_scan(8'h00);
      repeat (8) send_scan(8'($urandom));
      change_reg(CSR_IMAGE_WIDTH, 1);
      send_scan(8'($urandom));
   endtask

   // Hold the receiver off long enough to fill the pipe and stall the input
   task automatic test_backpressure();
      set_format(COLOR_GRAY, DEPTH_8, 24);
      tx_quiet = 1'b1;
      long_hold_ask++;
      send_scan(8'h00);
      repeat (24) send_scan(8'($urandom));
      tx_quiet = 1'b0;
      wait_for_results();
   endtask

   task automatic random_format();
      logic [2:0]  c;
      int unsigned d, w;
      if ($urandom_range(0, 7) == 0) begin
         c = 3'($urandom_range(0, 3) * 2 + 1);
      end else begin
         case ($urandom_range(0, 4))
            0:       c = COLOR_GRAY;
            1:       c = COLOR_RGB;
            2:       c = COLOR_PALETTE;
            3:       c = COLOR_GRAY_ALPHA;
            default: c = COLOR_RGBA;
         endcase
      end
      if ($urandom_range(0, 7) == 0) d = $urandom_range(0, 31);
      else if (c == COLOR_GRAY) d = 1 << $urandom_range(0, 4);
      else if (c == COLOR_PALETTE) d = 1 << $urandom_range(0, 3);
      else d = 8 << $urandom_range(0, 1);
      case ($urandom_range(0, 15))
         0:       w = 0;
         1:       w = $urandom_range(7, 12);
         default: w = $urandom_range(1, 6);
      endcase
      set_format(c, d, w);
   endtask

   // Mostly well-formed rows with random content, some cut short or overrun
   task automatic test_random_rows();
      int sent;
      int n;
      // fill the low palette so packed palette formats read written entries
      for (int i = 4; i < 16; i++) send_palette(8'(i), 24'($urandom));
      sent = 12;
      while (sent < 48) begin
         random_format();
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) begin
            send_palette(8'($urandom), 24'($urandom));
            sent++;
         end
         repeat ($urandom_range(1, 3)) begin
            send_scan(next_scan_byte());
            sent++;
            n = row_bytes();
            case ($urandom_range(0, 7))
               0:       n = $urandom_range(0, n);
               1:       n = n + $urandom_range(1, 3);
               default: ;
            endcase
            repeat (n) begin
               send_scan(next_scan_byte());
               sent++;
            end
            if ($urandom_range(0, 7) == 0) wait_for_results();
         end
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   // Receiver: random stall after each word, or a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_left = 0;
      end else begin
         if (long_hold_ask != long_hold_seen) begin
            rx_left        = LONG_HOLD;
            long_hold_seen = long_hold_ask;
         end else if (rsp_valid && !rsp_stall) begin
            rx_left = rx_quiet ? 0 : $urandom_range(0, 4);
         end
         if (rx_left > 0) begin
            rsp_stall <= 1'b1;
            rx_left = rx_left - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted result word with the oldest pending pixel
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected rsp word %h with nothing pending", rsp_data);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.red != want.red || rsp_data.green != want.green ||
                rsp_data.blue != want.blue || rsp_data.alpha != want.alpha ||
                rsp_data.pixel_last != want.pixel_last || rsp_data.status != want.status) begin
               if (mismatch_count < 10) begin
                  $display("rsp mismatch: exp r=%h g=%h b=%h a=%h last=%b st=%b",
                           want.red, want.green, want.blue, want.alpha, want.pixel_last,
                           want.status);
                  $display("              got r=%h g=%h b=%h a=%h last=%b st=%b",
                           rsp_data.red, rsp_data.green, rsp_data.blue, rsp_data.alpha,
                           rsp_data.pixel_last, rsp_data.status);
               end
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** png_scanline_to_rgba_core: FAILED **");
         $finish;
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_COLOR_TYPE;
      csr_wdata <= '0;
      reset_shadow();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_format();
      test_gray_depths();
      test_color_formats();
      test_palette();
      test_bad_config();
      test_mid_row_change();
      test_widest_row();
      test_backpressure();
      test_random_rows();

      wait_for_results();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("** png_scanline_to_rgba_core: PASSED **");
      end else begin
         $display("** png_scanline_to_rgba_core: FAILED **");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/png_s2r_pkg.sv
hw/rtl/png_s2r_unpack.sv
hw/rtl/png_s2r_color.sv
hw/rtl/png_scanline_to_rgba_core.sv
hw/rtl/png_s2r_checker.sv
tb/tb.sv
